FILE: rtl/htok_pkg.sv
package htok_pkg;

  // content length counter width
  localparam int LenBits = 32;

  // most results one input byte can cause
  localparam int MaxRes = 3;

  // result queue
  localparam int QueueDepth = 4;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int CountW = $clog2(QueueDepth + 1);

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [1:0] res_idx_t;

  // length of the header name that carries the body length
  localparam logic [3:0] ClLen = 4'd14;

  // ascii codes used by the parser
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChEqual   = 8'h3d;
  localparam logic [7:0] ChQuest   = 8'h3f;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChLf      = 8'h0a;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_PATH   = 3'd1,
    PH_QUERY  = 3'd2,
    PH_HEAD   = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    EV_CHAR     = 4'd0,
    EV_METHOD   = 4'd1,
    EV_PATH     = 4'd2,
    EV_QNAME    = 4'd3,
    EV_QVALUE   = 4'd4,
    EV_QFLAG    = 4'd5,
    EV_HNAME    = 4'd6,
    EV_HVALUE   = 4'd7,
    EV_HDRS_END = 4'd8,
    EV_PNAME    = 4'd9,
    EV_PVALUE   = 4'd10,
    EV_REQ_END  = 4'd11
  } event_t;

  // one queued result
  typedef struct packed {
    event_t     ev;
    logic [7:0] ch;
    logic       last;
  } result_t;

  // characters of "Content-Length"
  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h43;
      4'd1:    r = 8'h6f;
      4'd2:    r = 8'h6e;
      4'd3:    r = 8'h74;
      4'd4:    r = 8'h65;
      4'd5:    r = 8'h6e;
      4'd6:    r = 8'h74;
      4'd7:    r = 8'h2d;
      4'd8:    r = 8'h4c;
      4'd9:    r = 8'h65;
      4'd10:   r = 8'h6e;
      4'd11:   r = 8'h67;
      4'd12:   r = 8'h74;
      4'd13:   r = 8'h68;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // digit value, letters and anything else as code - 'A' + 10
  function automatic logic [7:0] hexval(input logic [7:0] c);
    logic [7:0] r;
    if (c >= ChZero && c <= ChNine) begin
      r = c - ChZero;
    end else begin
      r = c - 8'd55;
    end
    return r;
  endfunction

endpackage

FILE: rtl/http_request_tokenizer.sv
// http request tokenizer
// s_axis carries the raw request stream, one byte per beat in tdata.
// m_axis carries the token results: tuser is the event code (0 is a
// decoded character, the others end a method, path, query name, value
// or flag, header name or value, the header block, a body parameter name
// or value, or the whole request), tdata the decoded character (zero on
// end events), and tlast marks the final result caused by one input byte.
// One input byte gives zero to three results.
// A result is written into the queue register before m_axis offers it.
// Throughput: one byte per cycle while each byte gives at most one
// result and m_axis_tready stays high; m_axis drains one result per
// cycle while m_axis_tready is high. Results wait in a four entry queue,
// and s_axis_tready is high while at least three entries are free.
// Reset puts the parser at the start of a request (method phase, no
// content length) and empties the queue. When the receiver stalls, the
// queue fills and s_axis_tready drops; nothing is lost or reordered.
// A content length header sets how many body bytes are parsed as form
// parameters; after the end of request the next byte starts a new request.
module http_request_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_out
  output logic [3:0] m_axis_tuser,   // [3:0] event_res
  output logic       m_axis_tlast    // last
);

  // parser state
  htok_pkg::phase_t         phase, phase_next;
  logic                     skip_one, skip_one_next;
  logic                     skip_line, skip_line_next;
  logic [1:0]               hex_left, hex_left_next;
  logic [7:0]               hex_first, hex_first_next;
  logic                     name_pending, name_pending_next;
  logic [3:0]               match_pos, match_pos_next;
  logic                     match_ok, match_ok_next;
  logic                     digits_open, digits_open_next;
  logic [htok_pkg::LenBits-1:0] length_accum, length_accum_next;
  logic                     have_length, have_length_next;
  logic [htok_pkg::LenBits-1:0] body_left, body_left_next;

  // result queue
  htok_pkg::result_t        queue [htok_pkg::QueueDepth];
  htok_pkg::ptr_t           wr_ptr, rd_ptr;
  htok_pkg::count_t         count, count_next;

  // results of the current byte
  htok_pkg::event_t         res_ev [htok_pkg::MaxRes];
  logic [7:0]               res_ch [htok_pkg::MaxRes];
  htok_pkg::res_idx_t       res_n;

  logic                     in_beat;
  logic                     out_beat;
  logic [7:0]               c;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign c        = s_axis_tdata;

  // per-byte parse step
  always_comb begin
    logic                         add;
    logic [7:0]                   add_c;
    logic [7:0]                   hv;
    logic                         do_reset;
    logic                         matched;
    logic [htok_pkg::LenBits+3:0] acc_x10;
    logic [htok_pkg::LenBits-1:0] bl;

    phase_next        = phase;
    skip_one_next     = skip_one;
    skip_line_next    = skip_line;
    hex_left_next     = hex_left;
    hex_first_next    = hex_first;
    name_pending_next = name_pending;
    match_pos_next    = match_pos;
    match_ok_next     = match_ok;
    digits_open_next  = digits_open;
    length_accum_next = length_accum;
    have_length_next  = have_length;
    body_left_next    = body_left;

    for (int k = 0; k < htok_pkg::MaxRes; k++) begin
      res_ev[k] = htok_pkg::EV_CHAR;
      res_ch[k] = 8'h00;
    end
    res_n    = 2'd0;
    add      = 1'b0;
    add_c    = c;
    do_reset = 1'b0;
    matched  = match_ok && (match_pos == htok_pkg::ClLen);
    hv       = htok_pkg::hexval(hex_first);
    acc_x10  = '0;
    bl       = '0;

    // byte dispatch
    if (skip_line) begin
      if (c == htok_pkg::ChLf) begin
        skip_line_next = 1'b0;
      end
    end else if (skip_one) begin
      skip_one_next = 1'b0;
    end else if (hex_left != 2'd0) begin
      if (hex_left >= 2'd2) begin
        hex_first_next = htok_pkg::upcase(c);
        hex_left_next  = 2'd1;
      end else begin
        add           = 1'b1;
        add_c         = {hv[3:0], 4'b0000} + htok_pkg::hexval(htok_pkg::upcase(c));
        hex_left_next = 2'd0;
      end
    end else begin
      case (phase)
        htok_pkg::PH_PATH: begin
          if (c == htok_pkg::ChSpace) begin
            res_ev[0]      = htok_pkg::EV_PATH;
            res_n          = 2'd1;
            phase_next     = htok_pkg::PH_HEAD;
            skip_line_next = 1'b1;
          end else if (c == htok_pkg::ChQuest) begin
            res_ev[0]  = htok_pkg::EV_PATH;
            res_n      = 2'd1;
            phase_next = htok_pkg::PH_QUERY;
          end else if (c == htok_pkg::ChPercent) begin
            hex_left_next = 2'd2;
          end else begin
            add = 1'b1;
          end
        end
        htok_pkg::PH_QUERY: begin
          if (c == htok_pkg::ChEqual) begin
            res_ev[0]         = htok_pkg::EV_QNAME;
            res_n             = 2'd1;
            name_pending_next = 1'b1;
          end else if (c == htok_pkg::ChAmp || c == htok_pkg::ChSpace) begin
            res_ev[0]         = name_pending ? htok_pkg::EV_QVALUE : htok_pkg::EV_QFLAG;
            res_n             = 2'd1;
            name_pending_next = 1'b0;
            if (c == htok_pkg::ChSpace) begin
              phase_next     = htok_pkg::PH_HEAD;
              skip_line_next = 1'b1;
            end
          end else if (c == htok_pkg::ChPlus) begin
            add   = 1'b1;
            add_c = htok_pkg::ChSpace;
          end else if (c == htok_pkg::ChPercent) begin
            hex_left_next = 2'd2;
          end else begin
            add = 1'b1;
          end
        end
        htok_pkg::PH_HEAD: begin
          if (c == htok_pkg::ChColon && !name_pending) begin
            res_ev[0]         = htok_pkg::EV_HNAME;
            res_n             = 2'd1;
            name_pending_next = 1'b1;
            skip_one_next     = 1'b1;
            if (matched) begin
              length_accum_next = '0;
              digits_open_next  = 1'b1;
            end
          end else if (c == htok_pkg::ChPercent) begin
            hex_left_next = 2'd2;
          end else if (c == htok_pkg::ChCr) begin
            hex_left_next = hex_left;
          end else if (c == htok_pkg::ChLf) begin
            if (name_pending) begin
              // end of one header line
              res_ev[0]         = htok_pkg::EV_HVALUE;
              res_n             = 2'd1;
              have_length_next  = have_length || matched;
              name_pending_next = 1'b0;
              match_pos_next    = '0;
              match_ok_next     = 1'b1;
              digits_open_next  = 1'b1;
            end else if (have_length && length_accum != '0) begin
              // blank line, body follows
              res_ev[0]        = htok_pkg::EV_HDRS_END;
              res_n            = 2'd1;
              body_left_next   = length_accum;
              phase_next       = htok_pkg::PH_BODY;
              match_pos_next   = '0;
              match_ok_next    = 1'b1;
              digits_open_next = 1'b1;
            end else if (have_length) begin
              // zero length body
              res_ev[0] = htok_pkg::EV_HDRS_END;
              res_ev[1] = htok_pkg::EV_PVALUE;
              res_ev[2] = htok_pkg::EV_REQ_END;
              res_n     = 2'd3;
              do_reset  = 1'b1;
            end else begin
              res_ev[0] = htok_pkg::EV_HDRS_END;
              res_ev[1] = htok_pkg::EV_REQ_END;
              res_n     = 2'd2;
              do_reset  = 1'b1;
            end
          end else begin
            add = 1'b1;
          end
        end
        htok_pkg::PH_BODY: begin
          if (c == htok_pkg::ChEqual) begin
            res_ev[0] = htok_pkg::EV_PNAME;
            res_n     = 2'd1;
          end else if (c == htok_pkg::ChAmp) begin
            res_ev[0] = htok_pkg::EV_PVALUE;
            res_n     = 2'd1;
          end else if (c == htok_pkg::ChPlus) begin
            add   = 1'b1;
            add_c = htok_pkg::ChSpace;
          end else if (c == htok_pkg::ChPercent) begin
            hex_left_next = 2'd2;
          end else begin
            add = 1'b1;
          end
        end
        default: begin
          // method phase and unused phase codes
          if (c == htok_pkg::ChSpace) begin
            res_ev[0]  = htok_pkg::EV_METHOD;
            res_n      = 2'd1;
            phase_next = htok_pkg::PH_PATH;
          end else begin
            add = 1'b1;
          end
        end
      endcase
    end

    // character emit plus header name match and length digits
    if (add) begin
      res_ev[0] = htok_pkg::EV_CHAR;
      res_ch[0] = add_c;
      res_n     = 2'd1;
      if (phase == htok_pkg::PH_HEAD) begin
        if (!name_pending) begin
          if (match_pos < htok_pkg::ClLen && htok_pkg::cl_char(match_pos) == add_c) begin
            match_pos_next = match_pos + 4'd1;
          end else begin
            match_ok_next = 1'b0;
          end
        end else if (matched && digits_open) begin
          if (add_c >= htok_pkg::ChZero && add_c <= htok_pkg::ChNine) begin
            acc_x10 = ({4'b0000, length_accum} << 3) + ({4'b0000, length_accum} << 1)
                    + {{(htok_pkg::LenBits - 4){1'b0}}, 4'(add_c - htok_pkg::ChZero)};
            if (acc_x10[htok_pkg::LenBits+3:htok_pkg::LenBits] != 4'd0) begin
              length_accum_next = '1;
            end else begin
              length_accum_next = acc_x10[htok_pkg::LenBits-1:0];
            end
          end else begin
            digits_open_next = 1'b0;
          end
        end
      end
    end

    // body byte count and end of request
    if (phase == htok_pkg::PH_BODY) begin
      bl = (body_left != '0) ? body_left - 1'b1 : body_left;
      body_left_next = bl;
      if (bl == '0) begin
        res_ev[res_n]               = htok_pkg::EV_PVALUE;
        res_ev[2'(res_n + 2'd1)]    = htok_pkg::EV_REQ_END;
        res_ch[res_n]               = 8'h00;
        res_ch[2'(res_n + 2'd1)]    = 8'h00;
        res_n                       = res_n + 2'd2;
        do_reset                    = 1'b1;
      end
    end

    // back to the start of a request
    if (do_reset) begin
      phase_next        = htok_pkg::PH_METHOD;
      skip_one_next     = 1'b0;
      skip_line_next    = 1'b0;
      hex_left_next     = 2'd0;
      hex_first_next    = 8'h00;
      name_pending_next = 1'b0;
      match_pos_next    = '0;
      match_ok_next     = 1'b1;
      digits_open_next  = 1'b1;
      length_accum_next = '0;
      have_length_next  = 1'b0;
      body_left_next    = '0;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= htok_pkg::PH_METHOD;
      skip_one     <= 1'b0;
      skip_line    <= 1'b0;
      hex_left     <= 2'd0;
      hex_first    <= 8'h00;
      name_pending <= 1'b0;
      match_pos    <= '0;
      match_ok     <= 1'b1;
      digits_open  <= 1'b1;
      length_accum <= '0;
      have_length  <= 1'b0;
      body_left    <= '0;
    end else if (in_beat) begin
      phase        <= phase_next;
      skip_one     <= skip_one_next;
      skip_line    <= skip_line_next;
      hex_left     <= hex_left_next;
      hex_first    <= hex_first_next;
      name_pending <= name_pending_next;
      match_pos    <= match_pos_next;
      match_ok     <= match_ok_next;
      digits_open  <= digits_open_next;
      length_accum <= length_accum_next;
      have_length  <= have_length_next;
      body_left    <= body_left_next;
    end
  end

  // queue occupancy
  always_comb begin
    count_next = count;
    if (in_beat) begin
      count_next = count_next + htok_pkg::count_t'(res_n);
    end
    if (out_beat) begin
      count_next = count_next - 1'b1;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_beat) begin
        wr_ptr <= wr_ptr + htok_pkg::ptr_t'(res_n);
      end
      if (out_beat) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // queue entries, one per result of the byte
  always_ff @(posedge clk) begin
    if (in_beat) begin
      for (int k = 0; k < htok_pkg::MaxRes; k++) begin
        if (htok_pkg::res_idx_t'(k) < res_n) begin
          queue[htok_pkg::ptr_t'(wr_ptr + htok_pkg::ptr_t'(k))] <= '{
            ev:   res_ev[k],
            ch:   res_ch[k],
            last: (htok_pkg::res_idx_t'(k + 1) == res_n)
          };
        end
      end
    end
  end

  // handshakes and output beat
  assign s_axis_tready = (count <= htok_pkg::count_t'(htok_pkg::QueueDepth - htok_pkg::MaxRes));
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = queue[rd_ptr].ch;
  assign m_axis_tuser  = queue[rd_ptr].ev;
  assign m_axis_tlast  = queue[rd_ptr].last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= htok_pkg::count_t'(htok_pkg::QueueDepth))
    else $error("result queue overflow");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == htok_pkg::PH_BODY |-> body_left != '0)
    else $error("body phase with no bytes left");

  a_skip_line_head: assert property (@(posedge clk) disable iff (rst)
    skip_line |-> phase == htok_pkg::PH_HEAD)
    else $error("request line skip outside header phase");

  a_hex_left: assert property (@(posedge clk) disable iff (rst)
    in_beat && hex_left == 2'd2 |=> hex_left == 2'd1 || phase == htok_pkg::PH_METHOD)
    else $error("escape digit count out of step");
`endif

endmodule
